[rtl/core/gicc_pkg.sv]
// ----------------------------------------------------------------------------
// Greedy interval cover counter package
// Shared payload types and fixed field widths.
// ----------------------------------------------------------------------------
package gicc_pkg;

  localparam int unsigned VAL_W   = 14;
  localparam int unsigned COUNT_W = 9;

  typedef struct packed {
    logic [VAL_W-1:0] interval_start;
    logic [VAL_W-1:0] interval_end;
    logic             last_interval;
  } gicc_in_t;

  typedef struct packed {
    logic               covered_ok;
    logic [COUNT_W-1:0] cover_count;
    logic               overflow;
  } gicc_out_t;

endpackage

[rtl/core/greedy_interval_cover_count_top.sv]
// ----------------------------------------------------------------------------
// Greedy interval cover counter
// Loads intervals, sorts them by start and counts the fewest that cover the
// range from zero to full scale.
// ----------------------------------------------------------------------------
// Usage: intervals arrive on the in_* channel, one request per cycle while
// loading; each is clamped to FULL_SCALE and written to the interval memory.
// The request with last_interval set closes the set. The block then stalls
// its input while it sorts the memory by start (insertion sort, shifting
// each larger entry up one place) and runs the greedy scan. The single
// result then appears on the out_* channel and is held while out_stall is
// high; the next set may load as soon as the result is taken. Sort and scan
// run through the one memory, with a read port and a write port, which sets
// the processing time.
// Reset clears the fill count, the overflow flag and the control state;
// the memory keeps its contents, as only entries below the fill count are
// ever read. Items beyond MAX_INTERVALS are dropped and flag overflow.
// ----------------------------------------------------------------------------
module greedy_interval_cover_count_top
  import gicc_pkg::*;
#(
  parameter int unsigned MAX_INTERVALS = 256,
  parameter int unsigned FULL_SCALE    = 10000
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  gicc_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output gicc_out_t out_data
);

  localparam int unsigned AW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
  localparam int unsigned CW = $clog2(MAX_INTERVALS + 1);
  // The step count is bounded by the fill count and must still show saturation.
  localparam int unsigned NW = (CW > COUNT_W + 1) ? CW : COUNT_W + 1;
  localparam logic [VAL_W-1:0] FS = VAL_W'(FULL_SCALE);
  localparam logic [NW-1:0] CMAX = NW'((1 << COUNT_W) - 1);

  typedef enum logic [8:0] {
    S_LOAD  = 9'b000000001,
    S_SI    = 9'b000000010,  // fetch key element i
    S_SKEY  = 9'b000000100,  // capture key, fetch j-1
    S_SCMP  = 9'b000001000,  // compare j-1 with key
    S_SPUT  = 9'b000010000,  // place key at j
    S_GRD   = 9'b000100000,  // scan: issue read
    S_GCHK  = 9'b001000000,  // scan: examine data
    S_GSTEP = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state;
  logic [2*VAL_W-1:0] mem [MAX_INTERVALS];
  logic [2*VAL_W-1:0] rd_data;
  logic               wr_en;
  logic [AW-1:0]      wr_addr, rd_addr;
  logic [2*VAL_W-1:0] wr_data;

  logic [CW-1:0]      loaded_count;
  logic               overflow_seen;
  logic [CW-1:0]      idx_i, idx_j, pos;
  logic [2*VAL_W-1:0] key;
  logic [VAL_W-1:0]   covered, reach;
  logic [NW-1:0]      count;
  gicc_out_t          result;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  function automatic logic [VAL_W-1:0] clamp(input logic [VAL_W-1:0] v);
    return (v > FS) ? FS : v;
  endfunction

  wire accept = in_valid && !in_stall;
  assign in_stall  = (state != S_LOAD);
  assign out_valid = (state == S_OUT);
  assign out_data  = result;

  wire [VAL_W-1:0] rd_start = rd_data[2*VAL_W-1:VAL_W];
  wire [VAL_W-1:0] rd_end   = rd_data[VAL_W-1:0];

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = loaded_count[AW-1:0];
    wr_data = {clamp(in_data.interval_start), clamp(in_data.interval_end)};
    rd_addr = idx_i[AW-1:0];
    unique case (state)
      S_LOAD: wr_en = accept && (loaded_count < CW'(MAX_INTERVALS));
      S_SI:   rd_addr = idx_i[AW-1:0];
      S_SKEY: rd_addr = AW'(idx_j - 1'b1);
      S_SCMP: begin
        // Shift j-1 up one place while its start exceeds the key.
        wr_addr = idx_j[AW-1:0];
        wr_data = rd_data;
        wr_en   = (rd_start > key[2*VAL_W-1:VAL_W]);
        rd_addr = AW'(idx_j - 2'd2);
      end
      S_SPUT: begin
        wr_en   = 1'b1;
        wr_addr = idx_j[AW-1:0];
        wr_data = key;
      end
      S_GRD:  rd_addr = pos[AW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_LOAD;
      loaded_count  <= '0;
      overflow_seen <= 1'b0;
    end else begin
      unique case (state)
        S_LOAD: if (accept) begin
          if (loaded_count < CW'(MAX_INTERVALS)) begin
            loaded_count <= loaded_count + 1'b1;
          end else begin
            overflow_seen <= 1'b1;
          end
          if (in_data.last_interval) begin
            result.overflow <= overflow_seen ||
                               (loaded_count >= CW'(MAX_INTERVALS));
            idx_i <= CW'(1);
            state <= S_SI;
          end
        end
        S_SI: begin
          if (idx_i >= loaded_count) begin
            pos     <= '0;
            covered <= '0;
            reach   <= '0;
            count   <= '0;
            state   <= S_GSTEP;
          end else begin
            idx_j <= idx_i;
            state <= S_SKEY;
          end
        end
        S_SKEY: begin
          key   <= rd_data;
          state <= S_SCMP;
        end
        S_SCMP: begin
          if (rd_start > key[2*VAL_W-1:VAL_W]) begin
            idx_j <= idx_j - 1'b1;
            if (idx_j == CW'(1)) state <= S_SPUT;
          end else begin
            state <= S_SPUT;
          end
        end
        S_SPUT: begin
          idx_i <= idx_i + 1'b1;
          state <= S_SI;
        end
        S_GSTEP: begin
          // Greedy outer step: finished, or gather intervals from pos.
          if (covered >= FS) begin
            result.covered_ok  <= 1'b1;
            result.cover_count <= (count > CMAX) ? CMAX[COUNT_W-1:0]
                                                 : count[COUNT_W-1:0];
            state <= S_OUT;
          end else begin
            reach <= covered;
            state <= S_GRD;
          end
        end
        S_GRD: begin
          if (pos < loaded_count) begin
            state <= S_GCHK;
          end else if (reach > covered) begin
            covered <= reach;
            count   <= count + 1'b1;
            state   <= S_GSTEP;
          end else begin
            result.covered_ok  <= 1'b0;
            result.cover_count <= '0;
            state <= S_OUT;
          end
        end
        S_GCHK: begin
          if (rd_start <= covered) begin
            if (rd_end > reach) reach <= rd_end;
            pos   <= pos + 1'b1;
            state <= S_GRD;
          end else if (reach > covered) begin
            covered <= reach;
            count   <= count + 1'b1;
            state   <= S_GSTEP;
          end else begin
            result.covered_ok  <= 1'b0;
            result.cover_count <= '0;
            state <= S_OUT;
          end
        end
        S_OUT: if (!out_stall) begin
          loaded_count  <= '0;
          overflow_seen <= 1'b0;
          state         <= S_LOAD;
        end
        default: state <= S_LOAD;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    loaded_count <= CW'(MAX_INTERVALS))
    else $error("fill count beyond memory depth");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.covered_ok |-> out_data.cover_count == '0)
    else $error("count on failed cover");
  a_cover_mono: assert property (@(posedge clk) disable iff (rst)
    state == S_GSTEP && $past(state) != S_SI |-> covered <= FS || covered > $past(covered))
    else $error("coverage did not advance");
`endif

endmodule
